@@ rtl/awm_pkg.sv @@
package awm_pkg;

  localparam int MAX_PATTERN_DEF = 256;
  localparam int MAX_TEXT_DEF    = 65536;

  localparam int FUNC_W   = 2;
  localparam int LETTER_W = 5;
  localparam int INDEX_W  = 16;
  localparam int ALPHABET = 26;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_PATTERN = 2'd1,
    FUNC_TEXT    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_TEXT    = 2'd2
  } act_e;

  // One update of the letter-difference array.
  typedef struct packed {
    act_e                act;
    logic [LETTER_W-1:0] new_letter;
    logic                has_old;
    logic [LETTER_W-1:0] old_letter;
  } upd_t;

endpackage

@@ rtl/anagram_window_matcher.sv @@
// Channel  Handshake               Payload
// in       in_valid_i, in_stall_o   func_i, letter_i
// out      out_valid_o, out_stall_i start_index_o
//
// An accepted beat is first registered, with the job counters updated and the
// window ring read; the stage after that updates the 26 letter counters, checks
// them and sets the result register on a match. One beat is accepted every cycle while in_stall_o is low.
// Reset clears all counters; the ring keeps no reset and is read on every
// accepted beat, but its data is used only at slots that the current job has written.
// in_stall_o rises only while a result waits under out_stall_i and a second beat is already in flight.
module anagram_window_matcher #(
  parameter int MaxPattern = awm_pkg::MAX_PATTERN_DEF,
  parameter int MaxText    = awm_pkg::MAX_TEXT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [awm_pkg::FUNC_W-1:0]   func_i,
  input  logic [awm_pkg::LETTER_W-1:0] letter_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [awm_pkg::INDEX_W-1:0]  start_index_o
);

  localparam int RW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int PW = $clog2(MaxPattern + 1);
  localparam int TW = $clog2(MaxText + 1);
  localparam int XA = (TW > PW) ? TW : PW;
  localparam int XW = ((XA > awm_pkg::INDEX_W) ? XA : awm_pkg::INDEX_W) + 1;

  logic [PW-1:0] pat_len_q, pat_len_d;
  logic [TW-1:0] text_cnt_q, text_cnt_d;
  logic [RW-1:0] wr_ptr_q, wr_ptr_d;
  logic [RW-1:0] rd_ptr_q, rd_ptr_d;

  logic                         s1_valid_q, s1_valid_d;
  awm_pkg::act_e                s1_act_q;
  logic [awm_pkg::LETTER_W-1:0] s1_letter_q;
  logic                         s1_has_old_q;
  logic                         s1_full_q;
  logic [awm_pkg::INDEX_W-1:0]  s1_start_q;

  logic                        out_valid_q, out_valid_d;
  logic [awm_pkg::INDEX_W-1:0] start_q;

  logic in_accept, advance, apply;
  logic is_letter, do_clear, do_pat, do_text, do_win;
  logic has_old, full;
  logic [XW-1:0] tx, px, start_x;
  awm_pkg::act_e act;
  logic [awm_pkg::LETTER_W-1:0] old_letter;
  awm_pkg::upd_t upd;
  logic balanced;

  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign apply      = s1_valid_q && advance;

  assign is_letter = letter_i < awm_pkg::LETTER_W'(awm_pkg::ALPHABET);
  assign do_clear  = func_i == awm_pkg::FUNC_CLEAR;
  assign do_pat    = (func_i == awm_pkg::FUNC_PATTERN) && is_letter &&
                     (text_cnt_q == '0) && (pat_len_q < PW'(MaxPattern));
  assign do_text   = (func_i == awm_pkg::FUNC_TEXT) && is_letter &&
                     (text_cnt_q < TW'(MaxText));
  assign do_win    = do_text && (pat_len_q != '0);

  assign tx      = XW'(text_cnt_q);
  assign px      = XW'(pat_len_q);
  assign has_old = tx >= px;
  assign full    = (tx + XW'(1)) >= px;
  assign start_x = tx + XW'(1) - px;

  always_comb begin
    if (do_clear) begin
      act = awm_pkg::ACT_CLEAR;
    end else if (do_pat) begin
      act = awm_pkg::ACT_PATTERN;
    end else begin
      act = awm_pkg::ACT_TEXT;
    end
  end

  // The oldest window letter sits at the read pointer, which only starts to
  // move once the window is full.
  always_comb begin
    pat_len_d  = pat_len_q;
    text_cnt_d = text_cnt_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    if (in_accept) begin
      if (do_clear) begin
        pat_len_d  = '0;
        text_cnt_d = '0;
        wr_ptr_d   = '0;
        rd_ptr_d   = '0;
      end else if (do_pat) begin
        pat_len_d = pat_len_q + PW'(1);
      end else if (do_text) begin
        text_cnt_d = text_cnt_q + TW'(1);
        if (do_win) begin
          wr_ptr_d = (wr_ptr_q == RW'(MaxPattern - 1)) ? '0 : wr_ptr_q + RW'(1);
          if (has_old) begin
            rd_ptr_d = (rd_ptr_q == RW'(MaxPattern - 1)) ? '0 : rd_ptr_q + RW'(1);
          end
        end
      end
    end
  end

  assign s1_valid_d = (s1_valid_q && !advance) ? 1'b1 :
                      (in_accept && (do_clear || do_pat || do_win));
  assign out_valid_d = advance ? (apply && (s1_act_q == awm_pkg::ACT_TEXT) &&
                                  s1_full_q && balanced) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= '0;
      text_cnt_q  <= '0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pat_len_q   <= pat_len_d;
      text_cnt_q  <= text_cnt_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_act_q     <= act;
      s1_letter_q  <= letter_i;
      s1_has_old_q <= has_old;
      s1_full_q    <= full;
      s1_start_q   <= start_x[awm_pkg::INDEX_W-1:0];
    end
    if (apply) begin
      start_q <= s1_start_q;
    end
  end

  awm_ring #(
    .Depth (MaxPattern)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_accept && do_win),
    .waddr_i (wr_ptr_q),
    .wdata_i (letter_i),
    .re_i    (in_accept),
    .raddr_i (rd_ptr_q),
    .rdata_o (old_letter)
  );

  assign upd.act        = s1_act_q;
  assign upd.new_letter = s1_letter_q;
  assign upd.has_old    = s1_has_old_q;
  assign upd.old_letter = old_letter;

  awm_counts #(
    .MaxPattern (MaxPattern)
  ) u_counts (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (apply),
    .upd_i      (upd),
    .balanced_o (balanced)
  );

  assign out_valid_o   = out_valid_q;
  assign start_index_o = start_q;

  a_stall_needs_blocked_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q))
    else $error("input stalled without a blocked result");

  a_match_reaches_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply && (s1_act_q == awm_pkg::ACT_TEXT) && s1_full_q && balanced) |=>
    (out_valid_o && (start_index_o == $past(s1_start_q))))
    else $error("matching window not registered as a result");

  a_counts_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pat_len_q <= PW'(MaxPattern)) && (text_cnt_q <= TW'(MaxText)))
    else $error("job counter out of range");

  a_ptrs_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(wr_ptr_q) < 32'(MaxPattern)) && (32'(rd_ptr_q) < 32'(MaxPattern)))
    else $error("ring pointer out of range");

  a_pattern_frozen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((text_cnt_q != '0) && !(in_accept && do_clear)) |=> $stable(pat_len_q))
    else $error("pattern length changed after text started");

endmodule

@@ rtl/awm_ring.sv @@
module awm_ring #(
  parameter int Depth = awm_pkg::MAX_PATTERN_DEF,
  localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [awm_pkg::LETTER_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [awm_pkg::LETTER_W-1:0] rdata_o
);

  logic [awm_pkg::LETTER_W-1:0] mem [Depth];
  logic [awm_pkg::LETTER_W-1:0] rdata_q;

  // Read returns the old contents when both ports hit the same slot.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/awm_counts.sv @@
module awm_counts #(
  parameter int MaxPattern = awm_pkg::MAX_PATTERN_DEF,
  localparam int DW        = $clog2(MaxPattern + 1) + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  awm_pkg::upd_t upd_i,
  output logic          balanced_o
);

  logic signed [DW-1:0] diff_q [awm_pkg::ALPHABET];
  logic signed [DW-1:0] diff_d [awm_pkg::ALPHABET];
  logic [awm_pkg::ALPHABET-1:0] nonzero;

  // Each letter has its own cell; at most two cells move per pattern or text beat, and a clear beat zeroes them all.
  always_comb begin
    for (int i = 0; i < awm_pkg::ALPHABET; i++) begin
      logic inc;
      logic dec;
      inc = (upd_i.act == awm_pkg::ACT_TEXT) &&
            (upd_i.new_letter == awm_pkg::LETTER_W'(i));
      dec = ((upd_i.act == awm_pkg::ACT_PATTERN) &&
             (upd_i.new_letter == awm_pkg::LETTER_W'(i))) ||
            ((upd_i.act == awm_pkg::ACT_TEXT) && upd_i.has_old &&
             (upd_i.old_letter == awm_pkg::LETTER_W'(i)));
      if (upd_i.act == awm_pkg::ACT_CLEAR) begin
        diff_d[i] = '0;
      end else begin
        case ({inc, dec})
          2'b10:   diff_d[i] = diff_q[i] + DW'(1);
          2'b01:   diff_d[i] = diff_q[i] - DW'(1);
          default: diff_d[i] = diff_q[i];
        endcase
      end
      nonzero[i] = (diff_d[i] != '0);
    end
  end

  assign balanced_o = ~|nonzero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < awm_pkg::ALPHABET; i++) begin
        diff_q[i] <= '0;
      end
    end else if (en_i) begin
      for (int i = 0; i < awm_pkg::ALPHABET; i++) begin
        diff_q[i] <= diff_d[i];
      end
    end
  end

endmodule

@@ dv/tb_anagram_window_matcher.sv @@
module tb_anagram_window_matcher;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FUNC_W   = awm_pkg::FUNC_W;
  localparam int LETTER_W = awm_pkg::LETTER_W;
  localparam int INDEX_W  = awm_pkg::INDEX_W;
  localparam int ALPHABET = awm_pkg::ALPHABET;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int MAX_PATTERN = awm_pkg::MAX_PATTERN_DEF;
  localparam int MAX_TEXT    = awm_pkg::MAX_TEXT_DEF;
  localparam int RING_AW     = $clog2(MAX_PATTERN);
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 80;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [LETTER_W-1:0] letter;
  } letter_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   func = awm_pkg::FUNC_CLEAR;
  logic [LETTER_W-1:0] letter = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [INDEX_W-1:0]  start_index;

  anagram_window_matcher u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func),
    .letter_i      (letter),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .start_index_o (start_index)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Pending beats, and the window start indices still owed by the block.
  letter_beat_t       beat_q[$];
  logic [INDEX_W-1:0] match_index_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs     = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int error_cnt     = 0;
  int beats_in      = 0;
  int matches_seen  = 0;
  int jobs_sent     = 0;
  int highest_index = 0;
  int quiet_cycles  = 0;

  // Own copy of the matcher state.
  logic signed [9:0]   diff_by_letter [ALPHABET];
  int                  nonzero_cnt;
  int                  pat_len;
  int                  txt_cnt;
  logic [LETTER_W-1:0] window_ring [MAX_PATTERN];

  function automatic void bump(input logic [LETTER_W-1:0] l, input int delta);
    logic signed [9:0] prev;
    prev = diff_by_letter[l];
    diff_by_letter[l] = prev + 10'(delta);
    if (prev == 0 && diff_by_letter[l] != 0) begin
      nonzero_cnt++;
    end else if (prev != 0 && diff_by_letter[l] == 0) begin
      nonzero_cnt--;
    end
  endfunction

  function automatic void clear_job();
    foreach (diff_by_letter[i]) diff_by_letter[i] = '0;
    nonzero_cnt = 0;
    pat_len     = 0;
    txt_cnt     = 0;
  endfunction

  function automatic void predict_beat(input logic [FUNC_W-1:0] f,
                                       input logic [LETTER_W-1:0] l);
    int idx;
    if (f == awm_pkg::FUNC_CLEAR) begin
      clear_job();
    end else if (f == FUNC_UNUSED || l >= ALPHABET) begin
      // Ignored beat.
    end else if (f == awm_pkg::FUNC_PATTERN) begin
      if (txt_cnt == 0 && pat_len < MAX_PATTERN) begin
        bump(l, -1);
        pat_len++;
      end
    end else if (txt_cnt < MAX_TEXT) begin
      if (pat_len == 0) begin
        txt_cnt++;
      end else begin
        bump(l, 1);
        if (txt_cnt >= pat_len) begin
          bump(window_ring[RING_AW'((txt_cnt - pat_len) % MAX_PATTERN)], -1);
        end
        window_ring[RING_AW'(txt_cnt % MAX_PATTERN)] = l;
        txt_cnt++;
        if (txt_cnt >= pat_len && nonzero_cnt == 0) begin
          idx = txt_cnt - pat_len;
          match_index_q = {match_index_q, idx[INDEX_W-1:0]};
        end
      end
    end
  endfunction

  // Driver.
  letter_beat_t next_beat;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      func     <= awm_pkg::FUNC_CLEAR;
      letter   <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_beat(func, letter);
        beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_beat = beat_q.pop_front();
          in_valid <= 1'b1;
          func     <= next_beat.func;
          letter   <= next_beat.letter;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (match_index_q.size() == 0) begin
          $display("%0t: unexpected match, start_index %0d", $time, start_index);
          error_cnt++;
        end else begin
          if (start_index !== match_index_q[0]) begin
            $display("%0t: start_index mismatch, expected %0d, actual %0d",
                     $time, match_index_q[0], start_index);
            error_cnt++;
          end
          void'(match_index_q.pop_front());
        end
        matches_seen++;
        if (start_index > highest_index) highest_index = start_index;
      end
      if (hold_reqs != holds_done) begin
        holds_done <= holds_done + 1;
        hold_left  <= HOLD_CYCLES;
        out_stall  <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on beats moving on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send(input logic [FUNC_W-1:0] f, input int l);
    letter_beat_t b;
    b.func   = f;
    b.letter = l[LETTER_W-1:0];
    beat_q = {beat_q, b};
    if (f == awm_pkg::FUNC_CLEAR) jobs_sent++;
  endtask

  // Something the block should drop or that must be ignored mid-text.
  task automatic send_junk();
    case ($urandom_range(0, 2))
      0: send(FUNC_UNUSED, $urandom_range(0, 31));
      1: send(awm_pkg::FUNC_TEXT, $urandom_range(ALPHABET, 31));
      default: send(awm_pkg::FUNC_PATTERN, $urandom_range(0, 31));
    endcase
  endtask

  task automatic send_random_job(inout int counted);
    logic [LETTER_W-1:0] pat [64];
    logic [LETTER_W-1:0] tmp;
    int plen, span, base, tlen, splice_at, r, s;
    bit splice;
    send(awm_pkg::FUNC_CLEAR, $urandom_range(0, 31));
    r = $urandom_range(0, 99);
    if (r < 8) plen = 0;
    else if (r < 90) plen = $urandom_range(1, 6);
    else plen = $urandom_range(12, 40);
    span = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 3) : ALPHABET;
    base = $urandom_range(0, ALPHABET - span);
    for (int i = 0; i < plen; i++) begin
      pat[i] = LETTER_W'(base + $urandom_range(0, span - 1));
      send(awm_pkg::FUNC_PATTERN, pat[i]);
    end
    tlen = $urandom_range(1, plen + 24);
    splice = ($urandom_range(0, 1) != 0);
    splice_at = $urandom_range(0, tlen - 1);
    counted += 1 + plen + tlen;
    for (int i = 0; i < tlen; i++) begin
      // Drop a shuffled copy of the pattern in, so that matches are common.
      if (splice && i == splice_at) begin
        for (int j = plen - 1; j > 0; j--) begin
          s = $urandom_range(0, j);
          tmp = pat[j];
          pat[j] = pat[s];
          pat[s] = tmp;
        end
        for (int j = 0; j < plen; j++) send(awm_pkg::FUNC_TEXT, pat[j]);
        counted += plen;
      end
      if ($urandom_range(0, 99) < 10) send_junk();
      send(awm_pkg::FUNC_TEXT, base + $urandom_range(0, span - 1));
    end
  endtask

  task automatic send_random_phase();
    int counted;
    counted = 0;
    while (counted < ITEMS_PER_PHASE) send_random_job(counted);
  endtask

  task automatic wait_sent();
    while (beat_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [LETTER_W-1:0] long_pat [MAX_PATTERN + 2];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Phase one: sender idles now and then, receiver mostly stalls.
    send_idle_pct = 36;
    recv_idle_pct = 80;
    send(awm_pkg::FUNC_CLEAR, 31);
    send(awm_pkg::FUNC_TEXT, 5);          // empty pattern, counted only
    send(awm_pkg::FUNC_PATTERN, 0);       // pattern after text
    send(awm_pkg::FUNC_TEXT, 0);
    send(awm_pkg::FUNC_CLEAR, 0);
    send(awm_pkg::FUNC_PATTERN, 0);
    send(awm_pkg::FUNC_PATTERN, 1);
    send(awm_pkg::FUNC_PATTERN, 31);      // not a letter
    send(FUNC_UNUSED, 0);
    send(awm_pkg::FUNC_TEXT, 25);
    send(awm_pkg::FUNC_PATTERN, 2);       // pattern after text
    send(awm_pkg::FUNC_TEXT, 1);
    send(awm_pkg::FUNC_TEXT, 0);
    send(awm_pkg::FUNC_TEXT, 30);         // not a letter
    send(awm_pkg::FUNC_TEXT, 1);
    send(awm_pkg::FUNC_CLEAR, 16);
    send(awm_pkg::FUNC_PATTERN, 25);
    send(awm_pkg::FUNC_PATTERN, 16);
    send(awm_pkg::FUNC_TEXT, 16);
    send(awm_pkg::FUNC_TEXT, 25);
    send(awm_pkg::FUNC_TEXT, 25);
    send(awm_pkg::FUNC_TEXT, 16);
    send_random_phase();
    wait_sent();

    // Phase two: the other way round.
    send_idle_pct = 80;
    recv_idle_pct = 36;
    send_random_phase();
    wait_sent();

    // Phase three: no idling. A long output hold-off while every text beat
    // matches backs the block up onto its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_reqs = hold_reqs + 1;
    send(awm_pkg::FUNC_CLEAR, 0);
    send(awm_pkg::FUNC_PATTERN, 2);
    for (int i = 0; i < 24; i++) send(awm_pkg::FUNC_TEXT, 2);

    // Pattern beyond its maximum, then a text that repeats the first
    // MAX_PATTERN letters so that every full window matches.
    send(awm_pkg::FUNC_CLEAR, 0);
    for (int i = 0; i < MAX_PATTERN + 2; i++) begin
      long_pat[i] = LETTER_W'($urandom_range(0, ALPHABET - 1));
      send(awm_pkg::FUNC_PATTERN, long_pat[i]);
    end
    for (int i = 0; i < MAX_PATTERN + 2; i++) begin
      send(awm_pkg::FUNC_TEXT, long_pat[i % MAX_PATTERN]);
    end

    while (beat_q.size() != 0 || in_valid) @(negedge clk);
    while (match_index_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Covered %0d accepted beats over %0d jobs and %0d match indices (highest %0d),",
             beats_in, jobs_sent, matches_seen, highest_index);
    $display("with an over-long pattern, ignored beats and a long output hold-off.");
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
